// ===== design/xsr_pkg.sv =====
// Shared types and codes for the x86 sub-register mov/add/sub block.
// No dependencies; used by every module of the block.
package xsr_pkg;

	// command codes
	localparam logic [2:0] CMD_MOV = 3'd0;
	localparam logic [2:0] CMD_ADD = 3'd1;
	localparam logic [2:0] CMD_SUB = 3'd2;
	localparam logic [2:0] CMD_SHW = 3'd3;

	// operand view selectors
	typedef enum logic [3:0] {
		SEL_EAX = 4'd0,
		SEL_ECX = 4'd1,
		SEL_EDX = 4'd2,
		SEL_AX  = 4'd3,
		SEL_CX  = 4'd4,
		SEL_DX  = 4'd5,
		SEL_AL  = 4'd6,
		SEL_AH  = 4'd7,
		SEL_CL  = 4'd8,
		SEL_CH  = 4'd9,
		SEL_DL  = 4'd10,
		SEL_DH  = 4'd11,
		SEL_EIP = 4'd12
	} sel_t;

	// backing word of a view
	typedef enum logic [1:0] {
		RIDX_A  = 2'd0,
		RIDX_C  = 2'd1,
		RIDX_D  = 2'd2,
		RIDX_IP = 2'd3
	} reg_idx_t;

	// slice of the backing word
	typedef enum logic [1:0] {
		VW_FULL    = 2'd0,
		VW_HALF    = 2'd1,
		VW_BYTE_LO = 2'd2,
		VW_BYTE_HI = 2'd3
	} view_width_t;

	typedef struct packed {
		logic        ok;
		reg_idx_t    idx;
		view_width_t width;
	} view_t;

	// what one instruction does to state and output
	typedef struct packed {
		logic        wr_en;
		reg_idx_t    wr_idx;
		logic [31:0] wr_data;
		logic        show_valid;
		logic [31:0] show_value;
	} exec_t;

endpackage

// ===== design/xsr_view.sv =====
// Decodes a view selector and reads the zero-extended view value.
// Depends on xsr_pkg.
module xsr_view (
	input  logic [3:0]     sel,
	input  logic           eip_ok,
	input  logic [31:0]    reg_a,
	input  logic [31:0]    reg_c,
	input  logic [31:0]    reg_d,
	input  logic [31:0]    ip_next,
	output xsr_pkg::view_t view,
	output logic [31:0]    value
);

	logic [31:0] word;

	always_comb begin
		view = '{ok: 1'b1, idx: xsr_pkg::RIDX_A, width: xsr_pkg::VW_FULL};
		unique case (xsr_pkg::sel_t'(sel))
			xsr_pkg::SEL_EAX: view.idx = xsr_pkg::RIDX_A;
			xsr_pkg::SEL_ECX: view.idx = xsr_pkg::RIDX_C;
			xsr_pkg::SEL_EDX: view.idx = xsr_pkg::RIDX_D;
			xsr_pkg::SEL_AX: begin
				view.idx = xsr_pkg::RIDX_A;
				view.width = xsr_pkg::VW_HALF;
			end
			xsr_pkg::SEL_CX: begin
				view.idx = xsr_pkg::RIDX_C;
				view.width = xsr_pkg::VW_HALF;
			end
			xsr_pkg::SEL_DX: begin
				view.idx = xsr_pkg::RIDX_D;
				view.width = xsr_pkg::VW_HALF;
			end
			xsr_pkg::SEL_AL: begin
				view.idx = xsr_pkg::RIDX_A;
				view.width = xsr_pkg::VW_BYTE_LO;
			end
			xsr_pkg::SEL_AH: begin
				view.idx = xsr_pkg::RIDX_A;
				view.width = xsr_pkg::VW_BYTE_HI;
			end
			xsr_pkg::SEL_CL: begin
				view.idx = xsr_pkg::RIDX_C;
				view.width = xsr_pkg::VW_BYTE_LO;
			end
			xsr_pkg::SEL_CH: begin
				view.idx = xsr_pkg::RIDX_C;
				view.width = xsr_pkg::VW_BYTE_HI;
			end
			xsr_pkg::SEL_DL: begin
				view.idx = xsr_pkg::RIDX_D;
				view.width = xsr_pkg::VW_BYTE_LO;
			end
			xsr_pkg::SEL_DH: begin
				view.idx = xsr_pkg::RIDX_D;
				view.width = xsr_pkg::VW_BYTE_HI;
			end
			xsr_pkg::SEL_EIP: begin
				view.idx = xsr_pkg::RIDX_IP;
				view.ok = eip_ok;
			end
			default: view.ok = 1'b0;
		endcase
	end

	always_comb begin
		case (view.idx)
			xsr_pkg::RIDX_A: word = reg_a;
			xsr_pkg::RIDX_C: word = reg_c;
			xsr_pkg::RIDX_D: word = reg_d;
			default:         word = ip_next;
		endcase
		case (view.width)
			xsr_pkg::VW_FULL:    value = word;
			xsr_pkg::VW_HALF:    value = {16'd0, word[15:0]};
			xsr_pkg::VW_BYTE_LO: value = {24'd0, word[7:0]};
			default:             value = {24'd0, word[15:8]};
		endcase
	end

endmodule

// ===== design/xsr_exec.sv =====
// One instruction: operand views, add/sub, and merge into the destination.
// Depends on xsr_pkg and xsr_view.
module xsr_exec (
	input  logic [2:0]     cmd,
	input  logic [3:0]     dest_sel,
	input  logic           source_is_immediate,
	input  logic [3:0]     source_sel,
	input  logic [31:0]    immediate,
	input  logic [31:0]    reg_a,
	input  logic [31:0]    reg_c,
	input  logic [31:0]    reg_d,
	input  logic [31:0]    ip_next,
	output xsr_pkg::exec_t res
);

	xsr_pkg::view_t dv, sv;
	logic [31:0] a, b, dword, sval, r;
	logic is_alu, is_shw;

	assign is_shw = (cmd == xsr_pkg::CMD_SHW);
	assign is_alu = (cmd == xsr_pkg::CMD_MOV) || (cmd == xsr_pkg::CMD_ADD) ||
	                (cmd == xsr_pkg::CMD_SUB);

	xsr_view u_dst (
		.sel(dest_sel), .eip_ok(1'b0),
		.reg_a(reg_a), .reg_c(reg_c), .reg_d(reg_d), .ip_next(ip_next),
		.view(dv), .value(a)
	);

	// EIP as a source is legal for show only
	xsr_view u_src (
		.sel(source_sel), .eip_ok(is_shw),
		.reg_a(reg_a), .reg_c(reg_c), .reg_d(reg_d), .ip_next(ip_next),
		.view(sv), .value(sval)
	);

	assign b = source_is_immediate ? immediate : sval;

	// destination word for the merge; EIP is never a write target
	always_comb begin
		case (dv.idx)
			xsr_pkg::RIDX_A: dword = reg_a;
			xsr_pkg::RIDX_C: dword = reg_c;
			default:         dword = reg_d;
		endcase
	end

	always_comb begin
		case (cmd)
			xsr_pkg::CMD_ADD: r = a + b;
			xsr_pkg::CMD_SUB: r = a - b;
			default:          r = b;
		endcase
	end

	always_comb begin
		res.wr_en      = is_alu && dv.ok && (source_is_immediate || sv.ok);
		res.wr_idx     = dv.idx;
		res.show_valid = is_shw && (source_is_immediate || sv.ok);
		res.show_value = b;
		case (dv.width)
			xsr_pkg::VW_FULL:    res.wr_data = r;
			xsr_pkg::VW_HALF:    res.wr_data = {dword[31:16], r[15:0]};
			xsr_pkg::VW_BYTE_LO: res.wr_data = {dword[31:8], r[7:0]};
			default:             res.wr_data = {dword[31:16], r[7:0], dword[7:0]};
		endcase
	end

endmodule

// ===== design/x86_subregister_mov_add_sub_top.sv =====
// Top level: input register, architectural registers, result register.
// Depends on xsr_pkg, xsr_exec and xsr_view.
// An item is registered in the input stage at acceptance, executes from
// there, and a show result then goes to the output register. The register
// file update path is one stage. One item per cycle while no show is blocked.
// Reset: EAX, ECX, EDX and EIP clear to zero; input and output stages empty.
module x86_subregister_mov_add_sub_top (
	input  logic        clk,
	input  logic        arst_n,
	// instruction channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [3:0]  dest_sel,
	input  logic        source_is_immediate,
	input  logic [3:0]  source_sel,
	input  logic [31:0] immediate,
	// show result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] shown_value
);

	// input stage
	logic        valid_s1;
	logic [2:0]  cmd_s1;
	logic [3:0]  dest_sel_s1;
	logic        src_imm_s1;
	logic [3:0]  source_sel_s1;
	logic [31:0] immediate_s1;

	// architectural state
	logic [31:0] reg_a_q, reg_c_q, reg_d_q, ip_q;
	logic [31:0] ip_next;

	// output register
	logic        out_valid_q;
	logic [31:0] shown_value_q;

	xsr_pkg::exec_t res;
	logic out_free, fire_s1, load_s1;

	assign ip_next = ip_q + 32'd1;

	xsr_exec u_exec (
		.cmd(cmd_s1), .dest_sel(dest_sel_s1), .source_is_immediate(src_imm_s1),
		.source_sel(source_sel_s1), .immediate(immediate_s1),
		.reg_a(reg_a_q), .reg_c(reg_c_q), .reg_d(reg_d_q), .ip_next(ip_next),
		.res(res)
	);

	// the output slot is free if empty or being drained this cycle
	assign out_free = !out_valid_q || !out_stall;
	// items without a result never wait on the output side
	assign fire_s1  = valid_s1 && (!res.show_valid || out_free);
	assign load_s1  = !valid_s1 || fire_s1;
	assign in_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			cmd_s1        <= cmd;
			dest_sel_s1   <= dest_sel;
			src_imm_s1    <= source_is_immediate;
			source_sel_s1 <= source_sel;
			immediate_s1  <= immediate;
		end
	end

	// register file write and pointer advance, once per executed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_a_q <= '0;
			reg_c_q <= '0;
			reg_d_q <= '0;
			ip_q    <= '0;
		end else if (fire_s1) begin
			ip_q <= ip_next;
			if (res.wr_en) begin
				case (res.wr_idx)
					xsr_pkg::RIDX_A: reg_a_q <= res.wr_data;
					xsr_pkg::RIDX_C: reg_c_q <= res.wr_data;
					xsr_pkg::RIDX_D: reg_d_q <= res.wr_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && res.show_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && res.show_valid) begin
			shown_value_q <= res.show_value;
		end
	end

	assign out_valid   = out_valid_q;
	assign shown_value = shown_value_q;

	// pointer moves by exactly one per executed item and never otherwise
	a_ip_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 |=> ip_q == $past(ip_q) + 32'd1)
		else $error("instruction pointer did not advance by one");

	a_ip_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire_s1 |=> $stable(ip_q) && $stable(reg_a_q) && $stable(reg_c_q) &&
			$stable(reg_d_q))
		else $error("state changed without an executed item");

	// a show never overwrites a result still held by the consumer
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && res.show_valid) |-> out_free)
		else $error("show result overwrote a pending item");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && res.show_valid && out_valid_q && out_stall)
		else $error("input stalled without a blocked show");

endmodule

// ===== tb/xsr_shadow_checker.sv =====
// Checker for x86_subregister_mov_add_sub_top: keeps a shadow copy of EAX, ECX, EDX and EIP,
// replays every accepted item on it and compares each shown value in order.
// Depends on xsr_pkg for command codes and view selectors.
module xsr_shadow_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [2:0]        cmd,
	input  logic [3:0]        dest_sel,
	input  logic              source_is_immediate,
	input  logic [3:0]        source_sel,
	input  logic [31:0]       immediate,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [31:0]       shown_value,
	input  logic              run_over,
	output int unsigned       fail_count,
	output int unsigned       shows_pending,
	output int unsigned       shows_compared
);

	logic [31:0] arch_regs [4];     // indexed by reg_idx_t
	logic [31:0] shows_due [$];
	logic [31:0] due_val;
	int unsigned errs;
	int unsigned compared;
	bit          leftover_done;

	// map a selector to backing word, bit offset and mask; 0 when not usable
	function automatic logic view_decode(input logic [3:0] sel, input logic eip_ok,
			output xsr_pkg::reg_idx_t idx, output int unsigned sh,
			output logic [31:0] msk);
		logic ok;
		ok  = 1'b1;
		idx = xsr_pkg::RIDX_A;
		sh  = 0;
		msk = 32'hFFFF_FFFF;
		case (sel)
			xsr_pkg::SEL_EAX, xsr_pkg::SEL_AX, xsr_pkg::SEL_AL, xsr_pkg::SEL_AH:
				idx = xsr_pkg::RIDX_A;
			xsr_pkg::SEL_ECX, xsr_pkg::SEL_CX, xsr_pkg::SEL_CL, xsr_pkg::SEL_CH:
				idx = xsr_pkg::RIDX_C;
			xsr_pkg::SEL_EDX, xsr_pkg::SEL_DX, xsr_pkg::SEL_DL, xsr_pkg::SEL_DH:
				idx = xsr_pkg::RIDX_D;
			xsr_pkg::SEL_EIP: begin
				idx = xsr_pkg::RIDX_IP;
				ok  = eip_ok;
			end
			default: ok = 1'b0;
		endcase
		case (sel)
			xsr_pkg::SEL_AX, xsr_pkg::SEL_CX, xsr_pkg::SEL_DX: msk = 32'h0000_FFFF;
			xsr_pkg::SEL_AL, xsr_pkg::SEL_CL, xsr_pkg::SEL_DL: msk = 32'h0000_00FF;
			xsr_pkg::SEL_AH, xsr_pkg::SEL_CH, xsr_pkg::SEL_DH: begin
				msk = 32'h0000_00FF;
				sh  = 8;
			end
			default: ;
		endcase
		return ok;
	endfunction

	task automatic execute_instr(input logic [2:0] c, input logic [3:0] dsel,
			input logic imm_src, input logic [3:0] ssel, input logic [31:0] imm);
		xsr_pkg::reg_idx_t di, si;
		int unsigned       dsh, ssh;
		logic [31:0]       dm, sm, a, b, r;
		arch_regs[xsr_pkg::RIDX_IP] = arch_regs[xsr_pkg::RIDX_IP] + 32'd1;
		if (c == xsr_pkg::CMD_SHW) begin
			if (imm_src)
				shows_due.push_back(imm);
			else if (view_decode(ssel, 1'b1, si, ssh, sm))
				shows_due.push_back((arch_regs[si] >> ssh) & sm);
		end else if (c == xsr_pkg::CMD_MOV || c == xsr_pkg::CMD_ADD ||
				c == xsr_pkg::CMD_SUB) begin
			if (!view_decode(dsel, 1'b0, di, dsh, dm))
				return;
			if (imm_src) begin
				b = imm;
			end else begin
				if (!view_decode(ssel, 1'b0, si, ssh, sm))
					return;
				b = (arch_regs[si] >> ssh) & sm;
			end
			a = (arch_regs[di] >> dsh) & dm;
			case (c)
				xsr_pkg::CMD_MOV: r = b;
				xsr_pkg::CMD_ADD: r = a + b;
				default:          r = a - b;
			endcase
			arch_regs[di] = (arch_regs[di] & ~(dm << dsh)) | ((r & dm) << dsh);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (arch_regs[i])
				arch_regs[i] = '0;
			shows_due.delete();
			errs           = 0;
			compared       = 0;
			leftover_done  = 1'b0;
			fail_count     <= 0;
			shows_pending  <= 0;
			shows_compared <= 0;
		end else begin
			// results leave before this edge's item can have produced anything
			if (out_valid && !out_stall) begin
				if (shows_due.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("mismatch: shown_value %h with no show pending", shown_value);
				end else begin
					due_val = shows_due.pop_front();
					compared++;
					if (shown_value !== due_val) begin
						errs++;
						if (errs <= 10)
							$display("mismatch: shown_value expected %h got %h",
								due_val, shown_value);
					end
				end
			end
			if (in_valid && !in_stall)
				execute_instr(cmd, dest_sel, source_is_immediate, source_sel, immediate);
			if (run_over && !leftover_done) begin
				leftover_done = 1'b1;
				if (shows_due.size() != 0) begin
					errs += shows_due.size();
					$display("mismatch: %0d show results never arrived", shows_due.size());
				end
			end
			fail_count     <= errs;
			shows_pending  <= shows_due.size();
			shows_compared <= compared;
		end
	end

endmodule

// ===== tb/tb_x86_subregister_mov_add_sub_top.sv =====
// Testbench top for x86_subregister_mov_add_sub_top: clock, reset, instruction stimulus,
// result back-pressure, watchdog and verdict. Depends on xsr_pkg, the block and
// xsr_shadow_checker, which does all prediction and comparison.
module tb_x86_subregister_mov_add_sub_top;

	localparam int unsigned RANDOM_ITEMS = 450;
	localparam int unsigned IDLE_LIMIT   = 4000;  // far above any stall or gap stretch
	localparam int unsigned DRAIN_CYCLES = 8;

	// selectors with no meaning, and the command codes past show
	localparam logic [3:0] SEL_BAD_LO = 4'd13;
	localparam logic [3:0] SEL_BAD_HI = 4'd15;
	localparam logic [2:0] CMD_NOP_LO = 3'd4;
	localparam logic [2:0] CMD_NOP_HI = 3'd7;

	typedef enum int unsigned {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  cmd = '0;
	logic [3:0]  dest_sel = '0;
	logic        source_is_immediate = 1'b0;
	logic [3:0]  source_sel = '0;
	logic [31:0] immediate = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] shown_value;
	logic        run_over = 1'b0;

	int unsigned fail_count, shows_pending, shows_compared;
	int unsigned items_sent, show_items, nop_items, bad_operand_items;
	int unsigned burst_left, idle_cycles;
	int unsigned rx_left;
	rx_mode_t    rx_mode;

	x86_subregister_mov_add_sub_top DUT (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.cmd                 (cmd),
		.dest_sel            (dest_sel),
		.source_is_immediate (source_is_immediate),
		.source_sel          (source_sel),
		.immediate           (immediate),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.shown_value         (shown_value)
	);

	xsr_shadow_checker u_checker (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.cmd                 (cmd),
		.dest_sel            (dest_sel),
		.source_is_immediate (source_is_immediate),
		.source_sel          (source_sel),
		.immediate           (immediate),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.shown_value         (shown_value),
		.run_over            (run_over),
		.fail_count          (fail_count),
		.shows_pending       (shows_pending),
		.shows_compared      (shows_compared)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Receiver back-pressure: stretches of free flow, light and heavy random
	// stalls, and a fixed periodic stall, each lasting a random time.
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(16, 160);
		end else begin
			rx_left--;
		end
		case (rx_mode)
			RX_FLOW:  out_stall <= 1'b0;
			RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			RX_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
			default:  out_stall <= (rx_left % 3 == 0);
		endcase
	end

	// Watchdog: a run that stops moving items in either direction is a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
				$display("watchdog: nothing accepted for %0d cycles", IDLE_LIMIT);
				$display("status: fail");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Drive one item at the falling edge and hold it until accepted. After each
	// burst the sender may drop valid for a random gap; zero-length gaps give
	// back-to-back runs.
	task automatic issue(input logic [2:0] c, input logic [3:0] dsel, input logic imm_src,
			input logic [3:0] ssel, input logic [31:0] imm);
		int unsigned gap;
		cmd                 <= c;
		dest_sel            <= dsel;
		source_is_immediate <= imm_src;
		source_sel          <= ssel;
		immediate           <= imm;
		in_valid            <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		items_sent++;
		if (c == xsr_pkg::CMD_SHW)
			show_items++;
		else if (c > xsr_pkg::CMD_SHW)
			nop_items++;
		if (dsel >= xsr_pkg::SEL_EIP || (!imm_src && ssel >= xsr_pkg::SEL_EIP))
			bad_operand_items++;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap        = $urandom_range(0, 7);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	// mostly real views, some EIP, a few meaningless selectors
	function automatic logic [3:0] pick_sel();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return 4'($urandom_range(xsr_pkg::SEL_EAX, xsr_pkg::SEL_DH));
		else if (r < 93)
			return xsr_pkg::SEL_EIP;
		return 4'($urandom_range(SEL_BAD_LO, SEL_BAD_HI));
	endfunction

	function automatic logic [31:0] pick_imm();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return $urandom_range(0, 255);
			2: return 32'hFFFF_FFFF - $urandom_range(0, 255);
			default: return 32'd1 << $urandom_range(0, 31);
		endcase
	endfunction

	task automatic issue_random();
		logic [2:0] c;
		if ($urandom_range(0, 99) < 10)
			c = 3'($urandom_range(CMD_NOP_LO, CMD_NOP_HI));
		else
			c = 3'($urandom_range(xsr_pkg::CMD_MOV, xsr_pkg::CMD_SHW));
		issue(c, pick_sel(), ($urandom_range(0, 2) == 0), pick_sel(), pick_imm());
	endtask

	initial begin
		burst_left = $urandom_range(1, 12);
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: full, half and byte views, wraparound both ways
		issue(xsr_pkg::CMD_MOV, xsr_pkg::SEL_EAX, 1'b1, xsr_pkg::SEL_EAX, 32'hFFFF_FFFF);
		// truncated to the byte
		issue(xsr_pkg::CMD_MOV, xsr_pkg::SEL_AH, 1'b1, xsr_pkg::SEL_EAX, 32'h0001_2345);
		// byte wraps, AH untouched
		issue(xsr_pkg::CMD_ADD, xsr_pkg::SEL_AL, 1'b1, xsr_pkg::SEL_EAX, 32'h0000_00FF);
		issue(xsr_pkg::CMD_SHW, xsr_pkg::SEL_EAX, 1'b0, xsr_pkg::SEL_EAX, 32'h0);
		// 0 - 1 within 16 bits
		issue(xsr_pkg::CMD_SUB, xsr_pkg::SEL_CX, 1'b1, xsr_pkg::SEL_ECX, 32'h0000_0001);
		issue(xsr_pkg::CMD_SHW, xsr_pkg::SEL_EAX, 1'b0, xsr_pkg::SEL_ECX, 32'h0);
		issue(xsr_pkg::CMD_MOV, xsr_pkg::SEL_EDX, 1'b0, xsr_pkg::SEL_ECX, 32'h0);
		issue(xsr_pkg::CMD_ADD, xsr_pkg::SEL_DH, 1'b0, xsr_pkg::SEL_CL, 32'h0);
		issue(xsr_pkg::CMD_SUB, xsr_pkg::SEL_ECX, 1'b0, xsr_pkg::SEL_EAX, 32'h0);
		// 32-bit carry out dropped
		issue(xsr_pkg::CMD_ADD, xsr_pkg::SEL_EAX, 1'b0, xsr_pkg::SEL_EAX, 32'h0);
		issue(xsr_pkg::CMD_SHW, xsr_pkg::SEL_EAX, 1'b0, xsr_pkg::SEL_DX, 32'h0);
		issue(xsr_pkg::CMD_SHW, xsr_pkg::SEL_EAX, 1'b0, xsr_pkg::SEL_DH, 32'h0);
		issue(xsr_pkg::CMD_SHW, xsr_pkg::SEL_EAX, 1'b0, xsr_pkg::SEL_CH, 32'h0);
		issue(xsr_pkg::CMD_SHW, xsr_pkg::SEL_EAX, 1'b0, xsr_pkg::SEL_AL, 32'h0);
		// EIP: shown after its own increment, illegal as a mov/add/sub operand
		issue(xsr_pkg::CMD_SHW, xsr_pkg::SEL_EAX, 1'b0, xsr_pkg::SEL_EIP, 32'h0);
		issue(xsr_pkg::CMD_MOV, xsr_pkg::SEL_EIP, 1'b1, xsr_pkg::SEL_EAX, 32'hFFFF_FFFF);
		issue(xsr_pkg::CMD_ADD, xsr_pkg::SEL_EAX, 1'b0, xsr_pkg::SEL_EIP, 32'h0);
		// selectors without meaning, and an immediate overriding a bad source
		issue(xsr_pkg::CMD_MOV, SEL_BAD_HI, 1'b1, xsr_pkg::SEL_EAX, 32'h1234_5678);
		issue(xsr_pkg::CMD_SUB, xsr_pkg::SEL_EDX, 1'b0, SEL_BAD_LO, 32'h0);
		issue(xsr_pkg::CMD_SHW, SEL_BAD_HI, 1'b0, SEL_BAD_HI, 32'hFFFF_FFFF);
		issue(xsr_pkg::CMD_SHW, SEL_BAD_HI, 1'b1, SEL_BAD_HI, 32'hA5A5_A5A5);
		issue(xsr_pkg::CMD_MOV, xsr_pkg::SEL_DL, 1'b1, SEL_BAD_HI, 32'h0000_0000);
		// unknown commands only move EIP
		issue(CMD_NOP_LO, xsr_pkg::SEL_EAX, 1'b0, xsr_pkg::SEL_EAX, 32'h0);
		issue(CMD_NOP_HI, SEL_BAD_HI, 1'b1, SEL_BAD_HI, 32'hFFFF_FFFF);
		issue(xsr_pkg::CMD_SHW, xsr_pkg::SEL_EAX, 1'b0, xsr_pkg::SEL_EIP, 32'h0);

		repeat (RANDOM_ITEMS)
			issue_random();
		in_valid <= 1'b0;

		// let every show drain, then give trailing non-show items time to retire
		wait (shows_pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		run_over <= 1'b1;
		repeat (2) @(posedge clk);

		$display("covered %0d items: %0d shows, %0d unknown commands, %0d with EIP or bad operand",
			items_sent, show_items, nop_items, bad_operand_items);
		$display("compared %0d shown values under random gaps and output stalls", shows_compared);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
